@@ rtl/tqla_pkg.sv @@
// Shared types, constants and defaults for the tabular Q-learning agent.
// Used by every module of the block; depends on nothing.
package tqla_pkg;

    // Default fixed-point format of the value table (Q8.8).
    localparam int unsigned VALUE_WIDTH_DEF = 16;
    localparam int unsigned FRAC_BITS_DEF   = 8;

    // Table geometry: three states by three actions.
    localparam int unsigned NUM_ACTIONS = 3;
    localparam int unsigned NUM_ENTRIES = 9;
    localparam int unsigned ENTRY_AW    = 4;

    // Field widths.
    localparam int unsigned LEVEL_W  = 10;
    localparam int unsigned ROLL_W   = 7;
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned STATE_W  = 2;
    localparam int unsigned REWARD_W = 2;
    localparam int unsigned OUTVAL_W = 16;
    localparam int unsigned COEF_W   = 8;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPLORE_PERCENT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BALANCE_MARGIN  = 2'd3;

    localparam logic [7:0] LEARN_RATE_RST      = 8'd26;
    localparam logic [7:0] DISCOUNT_RST        = 8'd230;
    localparam logic [6:0] EXPLORE_PERCENT_RST = 7'd10;
    localparam logic [9:0] BALANCE_MARGIN_RST  = 10'd50;

    // Light states.
    localparam logic [STATE_W-1:0] LIGHT_LEFT     = 2'd0;
    localparam logic [STATE_W-1:0] LIGHT_RIGHT    = 2'd1;
    localparam logic [STATE_W-1:0] LIGHT_BALANCED = 2'd2;

    // Actions.
    localparam logic [ACTION_W-1:0] ACT_LEFT     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RIGHT    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STRAIGHT = 2'd2;

    // Reward codes on the result.
    localparam logic [REWARD_W-1:0] REWARD_POS = 2'b01;
    localparam logic [REWARD_W-1:0] REWARD_NEG = 2'b11;

    // Sequencer states.
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_CLASSIFY,
        SEQ_SCAN_CUR,
        SEQ_SCAN_NXT,
        SEQ_READ_OLD,
        SEQ_MUL_BEST,
        SEQ_MUL_STEP
    } seq_state_t;

    // Table access control from the sequencer.
    typedef struct packed {
        logic                wr_en;
        logic [ENTRY_AW-1:0] wr_addr;
        logic [ENTRY_AW-1:0] rd_addr;
    } tbl_ctrl_t;

    // Flat entry address of (row, column).
    function automatic logic [ENTRY_AW-1:0] entry_addr(input logic [STATE_W-1:0] row,
                                                       input logic [ACTION_W-1:0] col);
        entry_addr = ENTRY_AW'({row, 1'b0}) + ENTRY_AW'(row) + ENTRY_AW'(col);
    endfunction

endpackage

@@ rtl/tabular_q_learning_agent.sv @@
// Tabular Q-learning agent, epsilon-greedy, one update per request.
// A request is taken only while idle, so the next waits until this result is loaded.
// Each update runs row scans (three reads, one collect) on the single table read port,
// the current-row scan skipped when exploring, and two passes through the shared
// multiplier; an untaken result stalls input.
// Reset (aresetn low, synchronous): table reads as zero, config registers take defaults.
module tabular_q_learning_agent #(
    parameter int unsigned VALUE_WIDTH = tqla_pkg::VALUE_WIDTH_DEF,
    parameter int unsigned FRAC_BITS   = tqla_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // [9:0] left_level, [19:10] right_level, [29:20] next_left_level,
    // [39:30] next_right_level, [46:40] explore_roll, [48:47] random_action
    input  logic [55:0] s_tdata,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] chosen_action, [3:2] current_state, [4] explored,
    // [6:5] reward_given, [22:7] updated_value, [23] zero
    output logic [23:0] m_tdata,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [tqla_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tqla_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // Working width: holds reward term plus scaled best minus old without
    // overflow for any legal format.
    localparam int unsigned DW =
        ((VALUE_WIDTH > FRAC_BITS + 1) ? VALUE_WIDTH : FRAC_BITS + 1) + 3;
    localparam int unsigned XW = (DW + 1 > tqla_pkg::OUTVAL_W) ? DW + 1 : tqla_pkg::OUTVAL_W;

    localparam logic signed [DW-1:0] ONE_Q = DW'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [DW:0]   VMAX  = (DW+1)'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [DW:0]   VMIN  = -VMAX - (DW+1)'(1);

    // ---------------------------------------------------------------- config
    logic [7:0] learn_rate_reg;
    logic [7:0] discount_reg;
    logic [6:0] explore_percent_reg;
    logic [9:0] balance_margin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            learn_rate_reg      <= tqla_pkg::LEARN_RATE_RST;
            discount_reg        <= tqla_pkg::DISCOUNT_RST;
            explore_percent_reg <= tqla_pkg::EXPLORE_PERCENT_RST;
            balance_margin_reg  <= tqla_pkg::BALANCE_MARGIN_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                tqla_pkg::REG_LEARN_RATE:      learn_rate_reg      <= cfg_wdata[7:0];
                tqla_pkg::REG_DISCOUNT:        discount_reg        <= cfg_wdata[7:0];
                tqla_pkg::REG_EXPLORE_PERCENT: explore_percent_reg <= cfg_wdata[6:0];
                tqla_pkg::REG_BALANCE_MARGIN:  balance_margin_reg  <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    // Sort a sample pair into a light state; sums carry one extra bit.
    function automatic logic [tqla_pkg::STATE_W-1:0] classify(input logic [9:0] lv,
                                                              input logic [9:0] rv,
                                                              input logic [9:0] margin);
        if ({1'b0, lv} > ({1'b0, rv} + {1'b0, margin})) begin
            classify = tqla_pkg::LIGHT_LEFT;
        end else if ({1'b0, rv} > ({1'b0, lv} + {1'b0, margin})) begin
            classify = tqla_pkg::LIGHT_RIGHT;
        end else begin
            classify = tqla_pkg::LIGHT_BALANCED;
        end
    endfunction

    // ------------------------------------------------------------- sequencer
    tqla_pkg::seq_state_t state_reg, state_next;

    logic        s_accept;
    logic        out_free;
    logic [1:0]  scan_cnt_reg;
    logic        scan_done;

    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid || m_tready;
    assign scan_done = (scan_cnt_reg == 2'd3);

    // Request fields, held for the whole update.
    logic [9:0] left_reg, right_reg, next_left_reg, next_right_reg;
    logic [6:0] roll_reg;
    logic [1:0] rand_act_reg;

    // Decision state.
    logic [tqla_pkg::STATE_W-1:0]  cur_reg, nxt_reg;
    logic [tqla_pkg::ACTION_W-1:0] act_reg, best_col_reg;
    logic                          explored_reg, reward_pos_reg;
    logic signed [VALUE_WIDTH-1:0] best_val_reg, old_reg;

    // Result register, parts the sequencer from the output channel.
    logic                          m_valid_reg;
    logic [23:0]                   m_data_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tqla_pkg::SEQ_IDLE: begin
                if (s_accept) state_next = tqla_pkg::SEQ_CLASSIFY;
            end
            tqla_pkg::SEQ_CLASSIFY: begin
                // Exploring skips the greedy search of the current row.
                if (roll_reg < explore_percent_reg) state_next = tqla_pkg::SEQ_SCAN_NXT;
                else                                state_next = tqla_pkg::SEQ_SCAN_CUR;
            end
            tqla_pkg::SEQ_SCAN_CUR: begin
                if (scan_done) state_next = tqla_pkg::SEQ_SCAN_NXT;
            end
            tqla_pkg::SEQ_SCAN_NXT: begin
                if (scan_done) state_next = tqla_pkg::SEQ_READ_OLD;
            end
            tqla_pkg::SEQ_READ_OLD: state_next = tqla_pkg::SEQ_MUL_BEST;
            tqla_pkg::SEQ_MUL_BEST: state_next = tqla_pkg::SEQ_MUL_STEP;
            tqla_pkg::SEQ_MUL_STEP: begin
                // Hold until the result register can take the new value.
                if (out_free) state_next = tqla_pkg::SEQ_IDLE;
            end
            default: state_next = tqla_pkg::SEQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= tqla_pkg::SEQ_IDLE;
        else          state_reg <= state_next;
    end

    // ------------------------------------------------------ table + multiplier
    tqla_pkg::tbl_ctrl_t           tbl_ctrl;
    logic signed [VALUE_WIDTH-1:0] tbl_rd_data;
    logic signed [VALUE_WIDTH-1:0] new_value;

    logic                          mul_start;
    logic signed [DW-1:0]          mul_a;
    logic [7:0]                    mul_b;
    logic signed [DW-1:0]          mul_q;

    logic [tqla_pkg::ACTION_W-1:0] scan_col;
    logic signed [DW-1:0]          diff;
    logic signed [DW:0]            sum_raw;
    logic signed [DW:0]            sum_sat;
    logic signed [XW-1:0]          sum_ext;
    logic                          take_new;
    logic [tqla_pkg::ACTION_W-1:0] col_new;

    // Column issued this scan step; the last scan step only collects data.
    assign scan_col = scan_done ? tqla_pkg::ACT_STRAIGHT : scan_cnt_reg;

    // Output decode of the sequencer.
    always_comb begin
        s_tready         = (state_reg == tqla_pkg::SEQ_IDLE);
        tbl_ctrl.wr_en   = (state_reg == tqla_pkg::SEQ_MUL_STEP) && out_free;
        tbl_ctrl.wr_addr = tqla_pkg::entry_addr(cur_reg, act_reg);
        mul_start        = 1'b0;
        mul_a            = diff;
        mul_b            = learn_rate_reg;
        case (state_reg)
            tqla_pkg::SEQ_SCAN_CUR: tbl_ctrl.rd_addr = tqla_pkg::entry_addr(cur_reg, scan_col);
            tqla_pkg::SEQ_SCAN_NXT: tbl_ctrl.rd_addr = tqla_pkg::entry_addr(nxt_reg, scan_col);
            default:                tbl_ctrl.rd_addr = tqla_pkg::entry_addr(cur_reg, act_reg);
        endcase
        case (state_reg)
            tqla_pkg::SEQ_READ_OLD: begin
                // First pass: discount times best value of the next row.
                mul_start = 1'b1;
                mul_a     = DW'(best_val_reg);
                mul_b     = discount_reg;
            end
            tqla_pkg::SEQ_MUL_BEST: begin
                // Second pass: learning rate times (target - old).
                mul_start = 1'b1;
            end
            default: ;
        endcase
    end

    tqla_table #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (tbl_ctrl),
        .wr_data (new_value),
        .rd_data (tbl_rd_data)
    );

    tqla_mul #(
        .A_WIDTH (DW)
    ) u_mul (
        .aclk  (aclk),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .q     (mul_q)
    );

    // Running maximum over a row; strict compare keeps the first maximum.
    assign take_new = (scan_cnt_reg != 2'd0) &&
                      ((scan_cnt_reg == 2'd1) || (tbl_rd_data > best_val_reg));
    assign col_new  = take_new ? (scan_cnt_reg - 2'd1) : best_col_reg;

    // target - old, with the reward worth one unit of the fixed-point format.
    assign diff = (reward_pos_reg ? ONE_Q : -ONE_Q) + mul_q - DW'(tbl_rd_data);

    // old + step, then clamp to the table range.
    assign sum_raw = (DW+1)'(old_reg) + (DW+1)'(mul_q);
    always_comb begin
        if (sum_raw > VMAX)      sum_sat = VMAX;
        else if (sum_raw < VMIN) sum_sat = VMIN;
        else                     sum_sat = sum_raw;
    end
    assign new_value = sum_sat[VALUE_WIDTH-1:0];
    assign sum_ext   = XW'(sum_sat);

    // ------------------------------------------------------------- datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            tqla_pkg::SEQ_IDLE: begin
                if (s_accept) begin
                    left_reg       <= s_tdata[9:0];
                    right_reg      <= s_tdata[19:10];
                    next_left_reg  <= s_tdata[29:20];
                    next_right_reg <= s_tdata[39:30];
                    roll_reg       <= s_tdata[46:40];
                    rand_act_reg   <= s_tdata[48:47];
                end
            end
            tqla_pkg::SEQ_CLASSIFY: begin
                cur_reg        <= classify(left_reg, right_reg, balance_margin_reg);
                nxt_reg        <= classify(next_left_reg, next_right_reg, balance_margin_reg);
                explored_reg   <= (roll_reg < explore_percent_reg);
                reward_pos_reg <= (right_reg > left_reg);
                // Random action 3 saturates to walking straight.
                act_reg        <= (rand_act_reg > tqla_pkg::ACT_STRAIGHT) ?
                                  tqla_pkg::ACT_STRAIGHT : rand_act_reg;
            end
            tqla_pkg::SEQ_SCAN_CUR, tqla_pkg::SEQ_SCAN_NXT: begin
                if (take_new) best_val_reg <= tbl_rd_data;
                best_col_reg <= col_new;
                if (scan_done && (state_reg == tqla_pkg::SEQ_SCAN_CUR)) begin
                    act_reg <= col_new;
                end
            end
            tqla_pkg::SEQ_MUL_BEST: begin
                old_reg <= tbl_rd_data;
            end
            tqla_pkg::SEQ_MUL_STEP: begin
                if (out_free) begin
                    m_data_reg <= {1'b0,
                                   sum_ext[tqla_pkg::OUTVAL_W-1:0],
                                   reward_pos_reg ? tqla_pkg::REWARD_POS : tqla_pkg::REWARD_NEG,
                                   explored_reg,
                                   cur_reg,
                                   act_reg};
                end
            end
            default: ;
        endcase
    end

    // Scan counter: advance through three reads plus one collect step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_cnt_reg <= 2'd0;
        end else if ((state_reg == tqla_pkg::SEQ_SCAN_CUR) ||
                     (state_reg == tqla_pkg::SEQ_SCAN_NXT)) begin
            scan_cnt_reg <= scan_cnt_reg + 2'd1;
        end else begin
            scan_cnt_reg <= 2'd0;
        end
    end

    // Result valid: set on load, drop once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == tqla_pkg::SEQ_MUL_STEP) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ rtl/tqla_table.sv @@
// Value table: 9 signed entries, one registered read and one write per cycle.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on tqla_pkg.
module tqla_table #(
    parameter int unsigned VALUE_WIDTH = tqla_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tqla_pkg::tbl_ctrl_t           ctrl,
    input  logic signed [VALUE_WIDTH-1:0] wr_data,
    output logic signed [VALUE_WIDTH-1:0] rd_data
);

    logic signed [VALUE_WIDTH-1:0]      mem [tqla_pkg::NUM_ENTRIES];
    logic [tqla_pkg::NUM_ENTRIES-1:0]   valid_reg;
    logic signed [VALUE_WIDTH-1:0]      rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[ctrl.wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctrl.wr_en) begin
            valid_reg[ctrl.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (valid_reg[ctrl.rd_addr]) begin
            rd_data_reg <= mem[ctrl.rd_addr];
        end else begin
            rd_data_reg <= '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/tqla_mul.sv @@
// Shared scaling multiplier: signed operand times 8-bit fraction, product
// registered, result is the product shifted right by 8 (floor). Uses tqla_pkg.
module tqla_mul #(
    parameter int unsigned A_WIDTH = 19
) (
    input  logic                             aclk,
    input  logic                             start,
    input  logic signed [A_WIDTH-1:0]        a,
    input  logic [tqla_pkg::COEF_W-1:0]      b,
    output logic signed [A_WIDTH-1:0]        q
);

    localparam int unsigned PW = A_WIDTH + tqla_pkg::COEF_W;

    logic signed [PW:0]   prod_full;
    logic signed [PW-1:0] prod_reg;

    assign prod_full = (PW+1)'(a) * $signed({1'b0, b});

    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg <= prod_full[PW-1:0];
        end
    end

    // Drop the fraction bits; arithmetic, so negative values floor.
    assign q = prod_reg[PW-1:tqla_pkg::COEF_W];

endmodule
